// ===== design/dda_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dda_pkg
// Shared types for the line rasterizer: sequencer state encoding.
// ---------------------------------------------------------------------------
package dda_pkg;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_EMIT
  } dda_state_t;

endpackage

// ===== design/dda_line_rasterizer_unit.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dda_line_rasterizer_unit
// DDA line rasterizer: one line segment in, every pixel of the line out.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) takes one transaction per line: start
//   and end pixel coordinates. in_ready is high only while the unit is idle.
//   Output channel (out_valid/out_ready) returns one transaction per pixel,
//   from start to end inclusive; out_last_pixel marks the final pixel.
//   Per line: the accept cycle loads the deltas, then a restoring divider
//   computes the minor-axis slope one quotient bit per cycle, then the line
//   yields one pixel per cycle while out_ready is high. The unit works on
//   one line at a time.
//   Stall: when out_ready is low the current pixel is held on the output
//   ports and the position registers do not advance.
//   Reset (rst_n low, synchronous) returns the sequencer to idle and drops
//   any line in progress.
// ---------------------------------------------------------------------------
module dda_line_rasterizer_unit #(
  parameter int COORD_BITS = 6,
  parameter int FRAC_BITS  = 10
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [COORD_BITS-1:0] in_start_x,
  input  logic [COORD_BITS-1:0] in_start_y,
  input  logic [COORD_BITS-1:0] in_end_x,
  input  logic [COORD_BITS-1:0] in_end_y,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [COORD_BITS-1:0] out_pixel_x,
  output logic [COORD_BITS-1:0] out_pixel_y,
  output logic                  out_last_pixel
);
  import dda_pkg::*;

  // Position is signed fixed point with headroom for the rounding add.
  localparam int POS_W = COORD_BITS + FRAC_BITS + 2;
  // Dividend: |d_minor| << FRAC_BITS plus n/2 for round to nearest.
  localparam int NUM_W = COORD_BITS + FRAC_BITS + 1;
  localparam int CNT_W = $clog2(NUM_W);
  localparam int MAG_W = FRAC_BITS + 1;

  localparam logic signed [POS_W-1:0] ONE_FIXED  = POS_W'(1) << FRAC_BITS;
  localparam logic signed [POS_W-1:0] HALF_FIXED = POS_W'(1) << (FRAC_BITS - 1);

  dda_state_t state_r, state_nxt;

  logic signed [POS_W-1:0] pos_x_r, pos_x_nxt;
  logic signed [POS_W-1:0] pos_y_r, pos_y_nxt;
  logic signed [POS_W-1:0] step_x_r, step_x_nxt;
  logic signed [POS_W-1:0] step_y_r, step_y_nxt;
  logic [COORD_BITS-1:0]   steps_left_r, steps_left_nxt;
  logic                    major_x_r, major_x_nxt;
  logic                    minor_neg_r, minor_neg_nxt;
  logic [NUM_W-1:0]        quot_r, quot_nxt;
  logic [COORD_BITS-1:0]   rem_r, rem_nxt;
  logic [CNT_W-1:0]        div_cnt_r, div_cnt_nxt;

  // Input deltas
  logic signed [COORD_BITS:0] dx, dy;
  logic [COORD_BITS-1:0]      adx, ady, n_in, adm;
  logic                       x_major, dmaj_neg, dmin_neg, dmaj_zero;
  logic signed [POS_W-1:0]    major_step;

  // Divider datapath
  logic [COORD_BITS:0]     trial;
  logic                    fits;
  logic [MAG_W-1:0]        mag;
  logic signed [POS_W-1:0] minor_step;

  // Pixel rounding
  logic signed [POS_W-1:0] rnd_x, rnd_y;

  always_comb begin
    dx = $signed({1'b0, in_end_x}) - $signed({1'b0, in_start_x});
    dy = $signed({1'b0, in_end_y}) - $signed({1'b0, in_start_y});
    adx = dx[COORD_BITS] ? COORD_BITS'(-dx) : dx[COORD_BITS-1:0];
    ady = dy[COORD_BITS] ? COORD_BITS'(-dy) : dy[COORD_BITS-1:0];
    // Tie goes to x as the major axis.
    x_major   = (adx >= ady);
    n_in      = x_major ? adx : ady;
    adm       = x_major ? ady : adx;
    dmaj_neg  = x_major ? dx[COORD_BITS] : dy[COORD_BITS];
    dmin_neg  = x_major ? dy[COORD_BITS] : dx[COORD_BITS];
    dmaj_zero = (n_in == '0);
    if (dmaj_zero) begin
      major_step = '0;
    end else if (dmaj_neg) begin
      major_step = -ONE_FIXED;
    end else begin
      major_step = ONE_FIXED;
    end
  end

  // Restoring division: shift in one dividend bit, subtract when it fits.
  // The magnitude takes the quotient bit decided in this cycle as its LSB.
  always_comb begin
    trial = {rem_r, quot_r[NUM_W-1]};
    fits  = (trial >= {1'b0, steps_left_r});
    mag   = {quot_r[MAG_W-2:0], fits};
    if (steps_left_r == '0) begin
      minor_step = '0;
    end else if (minor_neg_r) begin
      minor_step = -$signed(POS_W'(mag));
    end else begin
      minor_step = $signed(POS_W'(mag));
    end
  end

  // Round to nearest, ties up; clamp below zero.
  always_comb begin
    rnd_x = pos_x_r + HALF_FIXED;
    rnd_y = pos_y_r + HALF_FIXED;
    out_pixel_x = rnd_x[POS_W-1] ? '0 : rnd_x[FRAC_BITS +: COORD_BITS];
    out_pixel_y = rnd_y[POS_W-1] ? '0 : rnd_y[FRAC_BITS +: COORD_BITS];
  end

  assign in_ready       = (state_r == ST_IDLE);
  assign out_valid      = (state_r == ST_EMIT);
  assign out_last_pixel = (steps_left_r == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_x_r      <= '0;
      pos_y_r      <= '0;
      step_x_r     <= '0;
      step_y_r     <= '0;
      steps_left_r <= '0;
      major_x_r    <= 1'b0;
      minor_neg_r  <= 1'b0;
      quot_r       <= '0;
      rem_r        <= '0;
      div_cnt_r    <= '0;
    end else begin
      pos_x_r      <= pos_x_nxt;
      pos_y_r      <= pos_y_nxt;
      step_x_r     <= step_x_nxt;
      step_y_r     <= step_y_nxt;
      steps_left_r <= steps_left_nxt;
      major_x_r    <= major_x_nxt;
      minor_neg_r  <= minor_neg_nxt;
      quot_r       <= quot_nxt;
      rem_r        <= rem_nxt;
      div_cnt_r    <= div_cnt_nxt;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    pos_x_nxt      = pos_x_r;
    pos_y_nxt      = pos_y_r;
    step_x_nxt     = step_x_r;
    step_y_nxt     = step_y_r;
    steps_left_nxt = steps_left_r;
    major_x_nxt    = major_x_r;
    minor_neg_nxt  = minor_neg_r;
    quot_nxt       = quot_r;
    rem_nxt        = rem_r;
    div_cnt_nxt    = div_cnt_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          // Load the line: start position, major step, dividend.
          pos_x_nxt      = $signed({2'b00, in_start_x, FRAC_BITS'(0)});
          pos_y_nxt      = $signed({2'b00, in_start_y, FRAC_BITS'(0)});
          step_x_nxt     = x_major ? major_step : '0;
          step_y_nxt     = x_major ? '0 : major_step;
          steps_left_nxt = n_in;
          major_x_nxt    = x_major;
          minor_neg_nxt  = dmin_neg;
          quot_nxt       = {1'b0, adm, FRAC_BITS'(0)} + NUM_W'(n_in >> 1);
          rem_nxt        = '0;
          div_cnt_nxt    = CNT_W'(NUM_W - 1);
          state_nxt      = ST_DIVIDE;
        end
      end
      ST_DIVIDE: begin
        rem_nxt  = fits ? COORD_BITS'(trial - {1'b0, steps_left_r})
                        : trial[COORD_BITS-1:0];
        quot_nxt = {quot_r[NUM_W-2:0], fits};
        div_cnt_nxt = div_cnt_r - 1'b1;
        if (div_cnt_r == '0) begin
          // Quotient complete: commit the minor-axis step.
          if (major_x_r) begin
            step_y_nxt = minor_step;
          end else begin
            step_x_nxt = minor_step;
          end
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_ready) begin
          if (steps_left_r == '0) begin
            state_nxt = ST_IDLE;
          end else begin
            pos_x_nxt      = pos_x_r + step_x_r;
            pos_y_nxt      = pos_y_r + step_y_r;
            steps_left_nxt = steps_left_r - 1'b1;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench
// Self-checking bench for the DDA line rasterizer unit.
// Feeds line segments, directed cases first and then random ones, over the
// input handshake. It predicts every pixel of each accepted segment with its
// own fixed-point DDA and checks the pixel stream in order. Both sides insert
// random gaps, and the receiver holds off for long stretches to back up the
// unit.
// ---------------------------------------------------------------------------
module testbench;

  localparam int COORD_BITS = 6;
  localparam int FRAC_BITS  = 10;
  localparam int COORD_MAX  = (1 << COORD_BITS) - 1;
  localparam longint ONE_FX  = longint'(1) << FRAC_BITS;
  localparam longint HALF_FX = longint'(1) << (FRAC_BITS - 1);
  localparam int RANDOM_LINES = 185;
  localparam int DRAIN_CYCLES = 120;
  localparam int CYCLE_LIMIT  = 1000000;

  typedef logic [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    coord_t sx;
    coord_t sy;
    coord_t ex;
    coord_t ey;
  } segment_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    logic   last;
  } pixel_t;

  // Clock and reset
  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  // Input channel
  logic   in_valid   = 1'b0;
  logic   in_ready;
  coord_t in_start_x = '0;
  coord_t in_start_y = '0;
  coord_t in_end_x   = '0;
  coord_t in_end_y   = '0;

  // Output channel
  logic   out_valid;
  logic   out_ready  = 1'b0;
  coord_t out_pixel_x;
  coord_t out_pixel_y;
  logic   out_last_pixel;

  // Segments waiting to be offered, and pixels expected back in order
  segment_t segment_q[$];
  pixel_t   pixel_q[$];

  int unsigned cycle_count  = 0;
  int unsigned fail_count   = 0;
  int unsigned segments_sent = 0;
  int unsigned pixels_seen  = 0;
  int unsigned in_gap       = 0;
  int unsigned out_gap      = 0;
  int unsigned hold_left    = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  dda_line_rasterizer_unit #(
    .COORD_BITS(COORD_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_start_x    (in_start_x),
    .in_start_y    (in_start_y),
    .in_end_x      (in_end_x),
    .in_end_y      (in_end_y),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_pixel_x   (out_pixel_x),
    .out_pixel_y   (out_pixel_y),
    .out_last_pixel(out_last_pixel)
  );

  // -------------------------------------------------------------------------
  // Pixel predictor
  // -------------------------------------------------------------------------

  // Minor-axis increment: (d << FRAC) / n, rounded to nearest, ties away
  // from zero, carrying the sign of d.
  function automatic longint minor_step(longint d, longint n);
    longint mag;
    if (n == 0) return 0;
    mag = ((d < 0 ? -d : d) * ONE_FX + n / 2) / n;
    return (d < 0) ? -mag : mag;
  endfunction

  // Round a fixed-point position to the nearest pixel, ties going up.
  function automatic coord_t round_to_pixel(longint pos_fx);
    longint r;
    r = pos_fx + HALF_FX;
    if (r < 0) r = 0;
    return coord_t'(r >>> FRAC_BITS);
  endfunction

  // Walk the segment from start to end inclusive and queue every pixel.
  function automatic void plot_segment(segment_t seg);
    longint dx, dy, adx, ady, n;
    longint step_x, step_y, pos_x, pos_y;
    pixel_t px;
    dx  = longint'(seg.ex) - longint'(seg.sx);
    dy  = longint'(seg.ey) - longint'(seg.sy);
    adx = (dx < 0) ? -dx : dx;
    ady = (dy < 0) ? -dy : dy;
    if (adx >= ady) begin
      n      = adx;
      step_x = (dx < 0) ? -ONE_FX : ((dx > 0) ? ONE_FX : 0);
      step_y = minor_step(dy, n);
    end else begin
      n      = ady;
      step_y = (dy < 0) ? -ONE_FX : ONE_FX;
      step_x = minor_step(dx, n);
    end
    pos_x = longint'(seg.sx) * ONE_FX;
    pos_y = longint'(seg.sy) * ONE_FX;
    for (longint k = 0; k <= n; k++) begin
      px.x    = round_to_pixel(pos_x);
      px.y    = round_to_pixel(pos_y);
      px.last = (k == n);
      pixel_q.push_back(px);
      pos_x += step_x;
      pos_y += step_y;
    end
  endfunction

  // -------------------------------------------------------------------------
  // Stimulus helpers
  // -------------------------------------------------------------------------

  task automatic add_segment(int sx, int sy, int ex, int ey);
    segment_t seg;
    seg.sx = coord_t'(sx);
    seg.sy = coord_t'(sy);
    seg.ex = coord_t'(ex);
    seg.ey = coord_t'(ey);
    segment_q.push_back(seg);
  endtask

  // Keep a coordinate inside the grid after adding an offset.
  function automatic int clamp_coord(int v);
    if (v < 0) return 0;
    if (v > COORD_MAX) return COORD_MAX;
    return v;
  endfunction

  // Short random segments half the time, some anywhere on the grid, some along
  // an axis or a diagonal.
  task automatic add_random_segment();
    int sx, sy, len, pick;
    pick = $urandom_range(0, 9);
    sx   = $urandom_range(0, COORD_MAX);
    sy   = $urandom_range(0, COORD_MAX);
    if (pick < 4) begin
      add_segment(sx, sy, $urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX));
    end else if (pick < 9) begin
      add_segment(sx, sy, clamp_coord(sx + $urandom_range(0, 16) - 8),
                  clamp_coord(sy + $urandom_range(0, 16) - 8));
    end else begin
      len = $urandom_range(0, COORD_MAX);
      case ($urandom_range(0, 2))
        0:       add_segment(sx, sy, clamp_coord(sx + len), sy);
        1:       add_segment(sx, sy, sx, clamp_coord(sy - len));
        default: add_segment(sx, sy, clamp_coord(sx - len), clamp_coord(sy - len));
      endcase
    end
  endtask

  // -------------------------------------------------------------------------
  // Driver: offer one segment per transaction, hold it until accepted
  // -------------------------------------------------------------------------
  always @(posedge clk) begin
    segment_t seg;
    logic     holding;
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_gap   = $urandom_range(0, 3);
    end else begin
      holding = in_valid && !in_ready;
      if (in_valid && in_ready) begin
        // Predict the whole pixel run the moment the segment is taken.
        plot_segment({in_start_x, in_start_y, in_end_x, in_end_y});
        segments_sent++;
        // Every third batch of 20 segments goes back to back.
        in_gap = ((segments_sent / 20) % 3 == 1) ? 0 : $urandom_range(0, 3);
      end
      if (!holding) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (segment_q.size() > 0) begin
          seg = segment_q.pop_front();
          in_valid   <= 1'b1;
          in_start_x <= seg.sx;
          in_start_y <= seg.sy;
          in_end_x   <= seg.ex;
          in_end_y   <= seg.ey;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // -------------------------------------------------------------------------
  // Monitor: accept pixels with random back-pressure and check each one
  // -------------------------------------------------------------------------
  always @(posedge clk) begin
    pixel_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (pixel_q.size() == 0) begin
          $error("unexpected pixel x=%0d y=%0d last=%0b",
                 out_pixel_x, out_pixel_y, out_last_pixel);
          fail_count++;
        end else begin
          want = pixel_q.pop_front();
          if (out_pixel_x !== want.x) begin
            $error("pixel_x mismatch: expected %0d, actual %0d", want.x, out_pixel_x);
            fail_count++;
          end
          if (out_pixel_y !== want.y) begin
            $error("pixel_y mismatch: expected %0d, actual %0d", want.y, out_pixel_y);
            fail_count++;
          end
          if (out_last_pixel !== want.last) begin
            $error("last_pixel mismatch: expected %0b, actual %0b",
                   want.last, out_last_pixel);
            fail_count++;
          end
        end
        pixels_seen++;
        // Hold off for a long stretch twice so the unit backs up its input.
        if (pixels_seen == 400 || pixels_seen == 2500)
          hold_left = 500;
        out_gap = ((pixels_seen / 150) % 3 == 2) ? 0 : $urandom_range(0, 3);
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (out_gap > 0) begin
        out_gap--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  // -------------------------------------------------------------------------
  // Test sequence
  // -------------------------------------------------------------------------
  initial begin
    // Directed: degenerate points at the corners
    add_segment(0, 0, 0, 0);
    add_segment(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX);
    add_segment(0, COORD_MAX, 0, COORD_MAX);
    // Full-length axis lines both ways
    add_segment(0, 0, COORD_MAX, 0);
    add_segment(COORD_MAX, COORD_MAX, 0, COORD_MAX);
    add_segment(0, 0, 0, COORD_MAX);
    add_segment(COORD_MAX, COORD_MAX, COORD_MAX, 0);
    // Full diagonals: tie between axes picks x as major
    add_segment(0, 0, COORD_MAX, COORD_MAX);
    add_segment(COORD_MAX, 0, 0, COORD_MAX);
    add_segment(COORD_MAX, COORD_MAX, 0, 0);
    add_segment(0, COORD_MAX, COORD_MAX, 0);
    // One line in each octant
    add_segment(10, 10, 30, 17);
    add_segment(10, 10, 17, 30);
    add_segment(30, 10, 10, 17);
    add_segment(17, 10, 10, 30);
    add_segment(30, 30, 10, 23);
    add_segment(30, 30, 23, 10);
    add_segment(10, 30, 30, 23);
    add_segment(10, 30, 17, 10);
    // Half-pixel positions: ties round upward in both directions
    add_segment(0, 0, 2, 1);
    add_segment(2, 1, 0, 0);
    add_segment(5, 9, 6, 7);
    // Shallow full-width and steep full-height slopes: largest rounding build-up
    add_segment(0, 0, COORD_MAX, 1);
    add_segment(COORD_MAX, 32, 0, 31);
    add_segment(1, COORD_MAX, 0, 0);

    repeat (RANDOM_LINES) add_random_segment();

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Wait for every segment to be taken and every pixel to come back.
    while (!(segment_q.size() == 0 && !in_valid && pixel_q.size() == 0)
           && cycle_count < CYCLE_LIMIT)
      @(negedge clk);

    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
    end else begin
      // Let any stray pixel show up before the final verdict.
      repeat (DRAIN_CYCLES) @(negedge clk);
      if (pixel_q.size() != 0) begin
        $error("%0d expected pixels never arrived", pixel_q.size());
        fail_count++;
      end
      if (fail_count == 0) begin
        $display("Regression PASS");
      end else begin
        $display("Regression FAIL");
      end
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/dda_pkg.sv
design/dda_line_rasterizer_unit.sv
verif/testbench.sv
